>>> src/bpagc_pkg.sv
package bpagc_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int PEAK_W   = 21;
  localparam int COUNT_W  = 32;
  localparam int CFG_W    = 17;

  // Gain limits, Q5.12
  localparam int GAIN_MIN = 4096;
  localparam int GAIN_MAX = 122880;

  // Peak thresholds: above HIGH_LIMIT cut the gain, below LOW_LIMIT raise it
  localparam int HIGH_LIMIT = 22936;
  localparam int LOW_LIMIT  = 9831;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] DC_OFFSET_RST  = -16'sd3300;
  localparam logic [GAIN_W-1:0]          START_GAIN_RST = 17'd12288;
  localparam logic                       ADAPT_RST      = 1'b1;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_DC_OFFSET    = 2'd0,
    CFG_START_GAIN   = 2'd1,
    CFG_ADAPT_ENABLE = 2'd2
  } cfg_index_t;

  // Input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;
  } item_t;

  // Result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
    logic                       block_done;
    logic [PEAK_W-1:0]          block_peak;
    logic [GAIN_W-1:0]          gain_now;
    logic [COUNT_W-1:0]         overflow_total;
  } result_t;

  // Precomputed next-gain choices, all already clamped
  typedef struct packed {
    logic [GAIN_W-1:0] keep;
    logic [GAIN_W-1:0] down;
    logic [GAIN_W-1:0] up;
  } gain_cand_t;

endpackage

>>> src/block_peak_agc_top.sv
// Block-peak automatic gain control.
//
// Input channel: item (sample_in, block_end) with item_valid / item_stall.
// A word is taken at a clock edge where item_valid is high and item_stall
// is low. block_end marks the last sample of a block.
// Output channel: result with result_valid / result_stall; one result word
// per input word, in order. block_peak is filled only on block_done.
// Configuration: cfg_we, cfg_index, cfg_data; 0 dc_offset, 1 start_gain
// (also loads the running gain), 2 adapt_enable. Write only while idle.
//
// A taken word is held in the input register, then moves into the result
// register when that has room. Throughput: one word per cycle while the receiver
// does not stall, set by the single 17x17 gain multiply and the gain feedback,
// both resolved in the compute cycle. A stalled receiver holds the result
// register; one more word fits in the input register before item_stall rises.
// Reset (rst, synchronous): both registers empty, gain back to 3.0,
// clip counter cleared, registers at their defaults.
module block_peak_agc_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  bpagc_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output bpagc_pkg::result_t           result,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bpagc_pkg::CFG_W-1:0]  cfg_data
);

  logic                              ir_valid;
  bpagc_pkg::item_t                  ir_word;
  logic                              step;
  logic [bpagc_pkg::GAIN_W-1:0]      gain;
  bpagc_pkg::gain_cand_t             cand;
  bpagc_pkg::result_t                res;

  // Move the held word into the result register when it has room
  assign step       = ir_valid && (!result_valid || !result_stall);
  assign item_stall = ir_valid && !step;

  bpagc_gain_prep u_gain_prep (
    .clk  (clk),
    .gain (gain),
    .cand (cand)
  );

  bpagc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .word      (ir_word),
    .cand      (cand),
    .gain      (gain),
    .res       (res)
  );

  // Input and result valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        ir_valid <= 1'b1;
      end else if (step) begin
        ir_valid <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      ir_word <= item;
    end
    if (step) begin
      result <= res;
    end
  end

  // A clipped word sits on one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.clipped) |->
      (result.sample_out == 16'sh7fff) || (result.sample_out == -16'sh8000))
    else $error("clipped sample not at a rail");

  // Empty input register never stalls the sender
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !ir_valid |-> !item_stall)
    else $error("stall with empty input register");

endmodule

>>> src/bpagc_gain_prep.sv
module bpagc_gain_prep (
  input  logic                            clk,
  input  logic [bpagc_pkg::GAIN_W-1:0]    gain,
  output bpagc_pkg::gain_cand_t           cand
);

  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x < 2^22
  localparam int          DIV10_SHIFT = 23;
  localparam logic [19:0] DIV10_MUL   = 20'd838861;
  // floor(x / 50) = (x * DIV50_MUL) >> DIV50_SHIFT, exact for x < 2^23
  localparam int          DIV50_SHIFT = 29;
  localparam logic [23:0] DIV50_MUL   = 24'd10737419;

  localparam int GW = bpagc_pkg::GAIN_W;

  function automatic logic [GW-1:0] clamp_gain(input logic [GW:0] g);
    logic [GW-1:0] r;
    if (g < (GW+1)'(bpagc_pkg::GAIN_MIN)) begin
      r = GW'(bpagc_pkg::GAIN_MIN);
    end else if (g > (GW+1)'(bpagc_pkg::GAIN_MAX)) begin
      r = GW'(bpagc_pkg::GAIN_MAX);
    end else begin
      r = g[GW-1:0];
    end
    return r;
  endfunction

  logic [19:0] x7;
  logic [22:0] x51;
  logic [39:0] prod_down;
  logic [46:0] prod_up;
  logic [GW:0] g_down;
  logic [GW:0] g_up;

  // gain * 0.7 and gain * 1.02, both floored
  always_comb begin
    x7        = {1'b0, gain, 2'b00} + {2'b00, gain, 1'b0} + {3'b000, gain};
    x51       = {1'b0, gain, 5'b0} + {2'b0, gain, 4'b0} + {5'b0, gain, 1'b0}
                + {6'b0, gain};
    prod_down = x7 * DIV10_MUL;
    prod_up   = x51 * DIV50_MUL;
    g_down    = {1'b0, prod_down[DIV10_SHIFT +: GW]};
    g_up      = prod_up[DIV50_SHIFT +: GW+1];
  end

  // Registered; the gain only adapts three or more samples after it changes
  always_ff @(posedge clk) begin
    cand.keep <= clamp_gain({1'b0, gain});
    cand.down <= clamp_gain(g_down);
    cand.up   <= clamp_gain(g_up);
  end

endmodule

>>> src/bpagc_core.sv
module bpagc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bpagc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          step,
  input  bpagc_pkg::item_t              word,
  input  bpagc_pkg::gain_cand_t         cand,
  output logic [bpagc_pkg::GAIN_W-1:0]  gain,
  output bpagc_pkg::result_t            res
);

  localparam int GW = bpagc_pkg::GAIN_W;
  localparam int PW = bpagc_pkg::PEAK_W;
  localparam int CW = bpagc_pkg::COUNT_W;

  // Configuration registers
  logic signed [15:0] dc_offset;
  logic [GW-1:0]      start_gain;
  logic               adapt_enable;

  // Block state
  logic [GW-1:0]      running_gain;
  logic [CW-1:0]      clip_count;
  logic signed [21:0] block_high;
  logic signed [21:0] block_low;
  logic [1:0]         block_len_seen;

  logic [GW-1:0]      running_gain_next;
  logic [CW-1:0]      clip_count_next;
  logic signed [21:0] block_high_next;
  logic signed [21:0] block_low_next;
  logic [1:0]         block_len_seen_next;

  logic signed [16:0] v;
  logic [16:0]        absv;
  logic [33:0]        mag;
  logic [PW-1:0]      qmag;
  logic signed [21:0] q;
  logic signed [21:0] neg_low;
  logic signed [21:0] peak_s;
  logic [PW-1:0]      peak;
  logic               clip_hi;
  logic               clip_lo;
  logic               clip;

  assign gain = running_gain;

  // Offset, gain, truncate toward zero
  always_comb begin
    v    = 17'(word.sample_in) + 17'(dc_offset);
    absv = v[16] ? 17'(-v) : 17'(v);
    mag  = absv * running_gain;
    qmag = mag[12 +: PW];
    q    = v[16] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  // Block min/max, peak, saturation and the next state
  always_comb begin
    if (block_len_seen == 2'd0) begin
      block_high_next = q;
      block_low_next  = q;
    end else begin
      block_high_next = (q > block_high) ? q : block_high;
      block_low_next  = (q < block_low) ? q : block_low;
    end
    neg_low = -block_low_next;
    peak_s  = (neg_low > block_high_next) ? neg_low : block_high_next;
    peak    = peak_s[PW-1:0];

    clip_hi = q > 22'sd32767;
    clip_lo = q < -22'sd32768;
    clip    = clip_hi || clip_lo;

    clip_count_next = clip_count;
    if (clip && (clip_count != {CW{1'b1}})) begin
      clip_count_next = clip_count + 1'b1;
    end

    running_gain_next = running_gain;
    if (word.block_end) begin
      block_len_seen_next = 2'd0;
      if (!adapt_enable) begin
        running_gain_next = start_gain;
      end else if (block_len_seen >= 2'd2) begin
        if (peak > PW'(bpagc_pkg::HIGH_LIMIT)) begin
          running_gain_next = cand.down;
        end else if (peak < PW'(bpagc_pkg::LOW_LIMIT)) begin
          running_gain_next = cand.up;
        end else begin
          running_gain_next = cand.keep;
        end
      end
    end else begin
      block_len_seen_next = (block_len_seen == 2'd3) ? 2'd3 : block_len_seen + 2'd1;
    end

    // Result word
    if (clip_hi) begin
      res.sample_out = 16'sh7fff;
    end else if (clip_lo) begin
      res.sample_out = -16'sh8000;
    end else begin
      res.sample_out = q[15:0];
    end
    res.clipped        = clip;
    res.block_done     = word.block_end;
    res.block_peak     = word.block_end ? peak : '0;
    res.gain_now       = running_gain_next;
    res.overflow_total = clip_count_next;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset      <= bpagc_pkg::DC_OFFSET_RST;
      start_gain     <= bpagc_pkg::START_GAIN_RST;
      adapt_enable   <= bpagc_pkg::ADAPT_RST;
      running_gain   <= bpagc_pkg::START_GAIN_RST;
      clip_count     <= '0;
      block_len_seen <= 2'd0;
    end else begin
      if (step) begin
        running_gain   <= running_gain_next;
        clip_count     <= clip_count_next;
        block_len_seen <= block_len_seen_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          bpagc_pkg::CFG_DC_OFFSET: begin
            dc_offset <= cfg_data[15:0];
          end
          bpagc_pkg::CFG_START_GAIN: begin
            start_gain   <= cfg_data[GW-1:0];
            running_gain <= cfg_data[GW-1:0];
          end
          bpagc_pkg::CFG_ADAPT_ENABLE: begin
            adapt_enable <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Min/max track only needs loading, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      block_high <= block_high_next;
      block_low  <= block_low_next;
    end
  end

  // An adapted gain always lands inside the clamp range
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg_we && word.block_end && adapt_enable && (block_len_seen >= 2'd2))
    |=> (running_gain >= GW'(bpagc_pkg::GAIN_MIN)) &&
        (running_gain <= GW'(bpagc_pkg::GAIN_MAX)))
    else $error("adapted gain out of range");

  // Clip counter never goes backwards
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> clip_count >= $past(clip_count))
    else $error("clip counter decreased");

  // Block end restarts the length count
  a_len_clear: assert property (@(posedge clk) disable iff (rst)
    (step && word.block_end) |=> block_len_seen == 2'd0)
    else $error("block length not cleared at block end");

  // The peak never sits below the largest product seen
  a_peak_cover: assert property (@(posedge clk) disable iff (rst)
    step |-> (peak_s >= block_high_next) && (peak_s >= 22'sd0))
    else $error("peak below block maximum");

endmodule

>>> tb/sv/tb_block_peak_agc_top.sv
`timescale 1ns / 100ps

module tb_block_peak_agc_top;

  localparam int SW   = bpagc_pkg::SAMPLE_W;
  localparam int GW   = bpagc_pkg::GAIN_W;
  localparam int PW   = bpagc_pkg::PEAK_W;
  localparam int CW   = bpagc_pkg::COUNT_W;
  localparam int CFGW = bpagc_pkg::CFG_W;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  bpagc_pkg::item_t     item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  bpagc_pkg::result_t   result;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [CFGW-1:0]      cfg_data = '0;

  block_peak_agc_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Words waiting to go out, and results the gain model says must come back
  bpagc_pkg::item_t   pending_words[$];
  bpagc_pkg::result_t agc_expected[$];
  bpagc_pkg::result_t want_word;

  // Gain model: registers and running state
  logic signed [SW-1:0] dc_offset_m;
  logic [GW-1:0]        start_gain_m;
  logic                 adapt_m;
  logic [GW-1:0]        gain_run;
  logic [CW-1:0]        clip_total;
  longint               blk_hi, blk_lo;
  int                   len_seen;

  // Bookkeeping
  bit idle_on = 1'b1;
  int send_wait = 0;
  int recv_wait = 0;
  int mismatches = 0;
  int words_checked = 0;
  int n_words = 0, n_blocks = 0, n_clipped = 0, n_cut = 0, n_raised = 0, n_writes = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Expected result for one accepted word; advances the model state
  function automatic bpagc_pkg::result_t agc_predict(bpagc_pkg::item_t w);
    bpagc_pkg::result_t r;
    longint  v, mag, q, s, peak, g;
    bit      clip;
    v = longint'(w.sample_in) + longint'(dc_offset_m);
    mag = (v < 0 ? -v : v) * longint'(gain_run);
    q = mag >> 12;
    if (v < 0) q = -q;
    // block extremes use the unsaturated product
    if (len_seen == 0) begin
      blk_hi = q;
      blk_lo = q;
    end else begin
      if (q > blk_hi) blk_hi = q;
      if (q < blk_lo) blk_lo = q;
    end
    if (len_seen < 3) len_seen++;
    clip = 1'b0;
    s = q;
    if (s > 32767) begin
      s = 32767;
      clip = 1'b1;
    end
    if (s < -32768) begin
      s = -32768;
      clip = 1'b1;
    end
    if (clip) n_clipped++;
    if (clip && clip_total != '1) clip_total++;
    peak = 0;
    if (w.block_end) begin
      n_blocks++;
      peak = (-blk_lo > blk_hi) ? -blk_lo : blk_hi;
      if (!adapt_m) begin
        gain_run = start_gain_m;
      end else if (len_seen >= 3) begin
        g = gain_run;
        if (peak > bpagc_pkg::HIGH_LIMIT) begin
          g = g * 7 / 10;
          n_cut++;
        end
        if (peak < bpagc_pkg::LOW_LIMIT) begin
          g = g * 102 / 100;
          n_raised++;
        end
        if (g < bpagc_pkg::GAIN_MIN) g = bpagc_pkg::GAIN_MIN;
        if (g > bpagc_pkg::GAIN_MAX) g = bpagc_pkg::GAIN_MAX;
        gain_run = GW'(g);
      end
      len_seen = 0;
    end
    n_words++;
    r.sample_out     = SW'(s);
    r.clipped        = clip;
    r.block_done     = w.block_end;
    r.block_peak     = PW'(peak);
    r.gain_now       = gain_run;
    r.overflow_total = clip_total;
    return r;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t: word %0d %s mismatch: got %0d, expected %0d",
             $time, words_checked, what, got, want);
  endtask

  // Drive one register write at this edge and mirror it in the model
  task automatic write_reg(bpagc_pkg::cfg_index_t idx, logic [CFGW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    n_writes++;
    case (idx)
      bpagc_pkg::CFG_DC_OFFSET: begin
        dc_offset_m = data[SW-1:0];
      end
      bpagc_pkg::CFG_START_GAIN: begin
        start_gain_m = data;
        gain_run     = data;
      end
      bpagc_pkg::CFG_ADAPT_ENABLE: begin
        adapt_m = data[0];
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [CFGW-1:0] dc, logic [CFGW-1:0] gain,
                            logic [CFGW-1:0] adapt);
    write_reg(bpagc_pkg::CFG_DC_OFFSET, dc);
    write_reg(bpagc_pkg::CFG_START_GAIN, gain);
    write_reg(bpagc_pkg::CFG_ADAPT_ENABLE, adapt);
    cfg_we <= 1'b0;
  endtask

  task automatic add_word(int s, bit last);
    bpagc_pkg::item_t w;
    w.sample_in = SW'(s);
    w.block_end = last;
    pending_words.push_back(w);
  endtask

  // Wait until every word is sent and every result is back
  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || item_valid || agc_expected.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mostly whole blocks around the current offset, some raw noise words
  task automatic queue_random_blocks(int count);
    int made, len, amp, k, delta;
    bit noise;
    made = 0;
    while (made < count) begin
      noise = ($urandom_range(0, 9) == 0);
      if (noise) len = $urandom_range(1, 6);
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 12);
      case ($urandom_range(0, 3))
        0: amp = 300;
        1: amp = 3000;
        2: amp = 12000;
        default: amp = 32767;
      endcase
      for (k = 0; k < len; k++) begin
        if (noise) begin
          add_word($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
        end else begin
          delta = $urandom_range(0, 2 * amp) - amp;
          add_word(delta - int'(dc_offset_m), k == len - 1);
        end
      end
      made += len;
    end
  endtask

  // Driver: one word at a time from the pending queue, random gaps after each
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait  <= 0;
    end else begin
      if (item_valid && !item_stall) agc_expected.push_back(agc_predict(item));
      if (item_valid && item_stall) begin
        // hold the word until taken
      end else if (send_wait > 0) begin
        item_valid <= 1'b0;
        send_wait  <= send_wait - 1;
      end else if (pending_words.size() != 0) begin
        item       <= pending_words.pop_front();
        item_valid <= 1'b1;
        send_wait  <= pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait    <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (agc_expected.size() == 0) begin
          note_mismatch("unexpected word, sample_out", result.sample_out, 0);
        end else begin
          want_word = agc_expected.pop_front();
          if (result.sample_out !== want_word.sample_out)
            note_mismatch("sample_out", result.sample_out, want_word.sample_out);
          if (result.clipped !== want_word.clipped)
            note_mismatch("clipped", result.clipped, want_word.clipped);
          if (result.block_done !== want_word.block_done)
            note_mismatch("block_done", result.block_done, want_word.block_done);
          if (result.block_peak !== want_word.block_peak)
            note_mismatch("block_peak", result.block_peak, want_word.block_peak);
          if (result.gain_now !== want_word.gain_now)
            note_mismatch("gain_now", result.gain_now, want_word.gain_now);
          if (result.overflow_total !== want_word.overflow_total)
            note_mismatch("overflow_total", result.overflow_total,
                          want_word.overflow_total);
        end
        words_checked++;
      end
      if (recv_wait > 0) begin
        result_stall <= 1'b1;
        recv_wait    <= recv_wait - 1;
      end else begin
        result_stall <= 1'b0;
        recv_wait    <= pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFGW-1:0] dc_w, gain_w, adapt_w;
    int ph;
    dc_offset_m  = bpagc_pkg::DC_OFFSET_RST;
    start_gain_m = bpagc_pkg::START_GAIN_RST;
    adapt_m      = bpagc_pkg::ADAPT_RST;
    gain_run     = bpagc_pkg::START_GAIN_RST;
    clip_total   = '0;
    blk_hi       = 0;
    blk_lo       = 0;
    len_seen     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Unity gain, no offset: products equal the samples, so thresholds are exact
    set_config(17'd0, 17'd4096, 17'd1);
    add_word(22936, 0); add_word(0, 0); add_word(-5, 1);     // at cut limit, kept
    add_word(-22937, 0); add_word(1, 0); add_word(1, 1);     // cut, clamped at 1.0
    add_word(100, 0); add_word(200, 0); add_word(9830, 1);   // raise
    add_word(7, 1);                                          // one-sample block
    add_word(-7, 0); add_word(-32768, 1);                    // two samples, clips low
    add_word(32767, 0); add_word(32767, 0); add_word(-1, 1); // clips high, cut
    drain();

    // Most negative offset, maximum gain, adaptation off
    set_config(17'h08000, 17'd122880, 17'd0);
    add_word(-32768, 0); add_word(32767, 0); add_word(0, 1);
    add_word(5, 1);
    drain();

    // Tiny peak at maximum gain: raise clamps at 30.0
    set_config(17'd32767, 17'd122880, 17'd1);
    add_word(-32768, 0); add_word(-32768, 0); add_word(-32760, 1);
    drain();

    // Gain written above range; adaptation cleared in the middle of a block
    set_config(17'd0, 17'd131071, 17'd1);
    add_word(0, 0); add_word(1, 0);
    drain();
    write_reg(bpagc_pkg::CFG_ADAPT_ENABLE, 17'd0);
    cfg_we <= 1'b0;
    add_word(-1, 1);
    drain();

    // Zero gain: everything is zero, then the raise clamps up to 1.0
    set_config(17'd0, 17'd0, 17'd1);
    add_word(3, 0); add_word(-3, 0); add_word(9, 1);
    drain();

    // Random phases, each with its own register settings
    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: dc_w = 17'd0;
        1: dc_w = 17'h08000;
        2: dc_w = 17'd32767;
        3: dc_w = 17'(-3300);
        default: dc_w = 17'($urandom_range(0, 65535));
      endcase
      dc_w[16] = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0: gain_w = 17'd4096;
        1: gain_w = 17'd122880;
        2: gain_w = 17'd0;
        3: gain_w = 17'd131071;
        default: gain_w = 17'($urandom_range(4096, 122880));
      endcase
      adapt_w = {16'($urandom_range(0, 65535)), 1'($urandom_range(0, 4) != 0)};
      set_config(dc_w, gain_w, adapt_w);
      idle_on = ($urandom_range(0, 3) != 0);
      queue_random_blocks(85);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d sample words in %0d blocks, %0d clipped, %0d register writes.",
             n_words, n_blocks, n_clipped, n_writes);
    $display("Gain was cut %0d times and raised %0d times; %0d mismatches.",
             n_cut, n_raised, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout: %0d results still expected", agc_expected.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
